// ----- rtl/ptd_pkg.sv -----
// Shared constants, types and reset table for the periodic task dispatcher.
package ptd_pkg;

  localparam int TASK_COUNT   = 4;
  localparam int MAX_TASKS    = 4;
  localparam int ACTIVE_TASKS = (TASK_COUNT < MAX_TASKS) ? TASK_COUNT : MAX_TASKS;
  localparam int TIME_W       = 32;
  localparam int TASK_W       = 2;
  localparam int CFG_IDX_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TASK0 = CFG_IDX_W'(0);

  typedef struct packed {
    logic              taken;
    logic [TIME_W-1:0] now;
  } link_t;

  typedef struct packed {
    logic missed;
    logic grant;
  } status_t;

  function automatic logic [TIME_W-1:0] reset_period(input logic [TASK_W-1:0] id);
    logic [TIME_W-1:0] p;
    case (id)
      2'd0:    p = TIME_W'(100);
      2'd1:    p = TIME_W'(500);
      2'd2:    p = TIME_W'(1000);
      2'd3:    p = TIME_W'(1000);
      default: p = TIME_W'(1000);
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/ptd_tick_if.sv -----
// Tick channel carrying the current time.
interface ptd_tick_if;
  logic                      valid;
  logic                      ready;
  logic [ptd_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

// ----- rtl/ptd_result_if.sv -----
// Result channel carrying the dispatch decision of one tick.
interface ptd_result_if;
  logic                       valid;
  logic                       ready;
  logic                       dispatched;
  logic [ptd_pkg::TASK_W-1:0] task_index;
  logic [ptd_pkg::MAX_TASKS-1:0] missed_mask;

  modport source (output valid, output dispatched, output task_index,
                  output missed_mask, input ready);
  modport sink   (input valid, input dispatched, input task_index,
                  input missed_mask, output ready);
endinterface

// ----- rtl/ptd_cfg_if.sv -----
// Configuration write channel for the task periods.
interface ptd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ptd_pkg::CFG_IDX_W-1:0] index;
  logic [ptd_pkg::TIME_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/periodic_task_dispatcher_top.sv -----
// Top level: row of task cells feeding a registered result stage.
// The result of an accepted tick is registered in the output register in the cycle after it is accepted.
// Throughput: one tick per cycle while the result is not stalled; the cell row is combinational.
// A tick is taken whenever the output register is empty or drains that cycle.
// Reset (synchronous): periods return to 100/500/1000/1000, start times and
// deadlines clear, the output register empties.
module periodic_task_dispatcher_top (
  input logic          clk,
  input logic          rst,
  ptd_tick_if.sink     tick,
  ptd_result_if.source result,
  ptd_cfg_if.sink      cfg
);

  ptd_pkg::link_t   link   [0:ptd_pkg::ACTIVE_TASKS];
  ptd_pkg::status_t status [0:ptd_pkg::MAX_TASKS-1];

  logic                          accept;
  logic                          any_grant;
  logic [ptd_pkg::TASK_W-1:0]    index_next;
  logic [ptd_pkg::MAX_TASKS-1:0] missed_next;
  logic [ptd_pkg::MAX_TASKS-1:0] grant_vec;

  assign cfg.ready  = 1'b1;
  assign tick.ready = !result.valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  assign link[0].taken = 1'b0;
  assign link[0].now   = tick.now_ms;

  for (genvar i = 0; i < ptd_pkg::MAX_TASKS; i++) begin : g_cell
    if (i < ptd_pkg::ACTIVE_TASKS) begin : g_on
      ptd_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_id  (ptd_pkg::TASK_W'(i)),
        .cfg_we   (cfg.valid && (cfg.index ==
                   ptd_pkg::REG_PERIOD_TASK0 + ptd_pkg::CFG_IDX_W'(i))),
        .cfg_data (cfg.data),
        .accept   (accept),
        .link_in  (link[i]),
        .link_out (link[i+1]),
        .status   (status[i])
      );
    end else begin : g_off
      assign status[i] = '0;
    end
  end

  always_comb begin
    index_next = '0;
    for (int i = 0; i < ptd_pkg::MAX_TASKS; i++) begin
      grant_vec[i]   = status[i].grant;
      missed_next[i] = status[i].missed;
      if (status[i].grant) begin
        index_next = index_next | ptd_pkg::TASK_W'(i);
      end
    end
    any_grant = |grant_vec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.dispatched  <= any_grant;
      result.task_index  <= index_next;
      result.missed_mask <= missed_next;
    end
  end

`ifndef SYNTHESIS
  a_one_grant: assert property (@(posedge clk) disable iff (rst) $onehot0(grant_vec))
    else $error("more than one task granted in a tick");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted tick produced no result");

  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    (accept && !any_grant) |=> (!result.dispatched && result.task_index == '0))
    else $error("idle tick reported a task index");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !tick.ready)
    else $error("tick taken while result stalled");
`endif

endmodule

// ----- rtl/ptd_cell.sv -----
// One task cell: period, last start and deadline, with priority pass-through.
module ptd_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ptd_pkg::TASK_W-1:0] cell_id,
  input  logic                       cfg_we,
  input  logic [ptd_pkg::TIME_W-1:0] cfg_data,
  input  logic                       accept,
  input  ptd_pkg::link_t             link_in,
  output ptd_pkg::link_t             link_out,
  output ptd_pkg::status_t           status
);

  logic [ptd_pkg::TIME_W-1:0] period;
  logic [ptd_pkg::TIME_W-1:0] last_start;
  logic [ptd_pkg::TIME_W-1:0] deadline;
  logic [ptd_pkg::TIME_W-1:0] elapsed;
  logic                       due;

  always_comb begin
    elapsed        = link_in.now - last_start;
    due            = (elapsed >= period);
    status.grant   = due && !link_in.taken;
    status.missed  = (deadline != '0) && (link_in.now > deadline);
    link_out.taken = link_in.taken || due;
    link_out.now   = link_in.now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= ptd_pkg::reset_period(cell_id);
      last_start <= '0;
      deadline   <= '0;
    end else begin
      if (cfg_we) begin
        period <= cfg_data;
      end
      if (accept && status.grant) begin
        last_start <= link_in.now;
        deadline   <= link_in.now + period;
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench for periodic_task_dispatcher_top: directed and random ticks against a local scheduler.
module tb_top;

  localparam logic [ptd_pkg::CFG_IDX_W-1:0] REG_PERIOD_TASK1 =
    ptd_pkg::REG_PERIOD_TASK0 + ptd_pkg::CFG_IDX_W'(1);
  localparam logic [ptd_pkg::CFG_IDX_W-1:0] REG_PERIOD_TASK2 =
    ptd_pkg::REG_PERIOD_TASK0 + ptd_pkg::CFG_IDX_W'(2);
  localparam logic [ptd_pkg::CFG_IDX_W-1:0] REG_PERIOD_TASK3 =
    ptd_pkg::REG_PERIOD_TASK0 + ptd_pkg::CFG_IDX_W'(3);
  localparam logic [ptd_pkg::CFG_IDX_W-1:0] REG_STRAY_LOW    =
    ptd_pkg::CFG_IDX_W'(ptd_pkg::MAX_TASKS);
  localparam logic [ptd_pkg::CFG_IDX_W-1:0] REG_STRAY_HIGH   = '1;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic                          dispatched;
    logic [ptd_pkg::TASK_W-1:0]    task_index;
    logic [ptd_pkg::MAX_TASKS-1:0] missed_mask;
  } tick_outcome_t;

  logic clk;
  logic rst;

  ptd_tick_if   tick_ch();
  ptd_result_if result_ch();
  ptd_cfg_if    cfg_ch();

  periodic_task_dispatcher_top dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  logic [ptd_pkg::TIME_W-1:0] period_q     [ptd_pkg::MAX_TASKS];
  logic [ptd_pkg::TIME_W-1:0] last_start_q [ptd_pkg::MAX_TASKS];
  logic [ptd_pkg::TIME_W-1:0] deadline_q   [ptd_pkg::MAX_TASKS];

  tick_outcome_t pending_outcomes [$];
  tick_outcome_t got_outcome;
  tick_outcome_t want_outcome;
  logic [ptd_pkg::TIME_W-1:0] tick_time;

  int error_count = 0;
  int cycles_seen = 0;
  bit quiet_tail  = 1'b0;
  bit rx_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles_seen <= cycles_seen + 1;
    if (cycles_seen >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic tick_outcome_t schedule_tick(input logic [ptd_pkg::TIME_W-1:0] now);
    tick_outcome_t              outcome;
    logic [ptd_pkg::TIME_W-1:0] elapsed;
    outcome = '0;
    for (int i = 0; i < ptd_pkg::ACTIVE_TASKS; i++) begin
      if (deadline_q[i] != '0 && now > deadline_q[i]) outcome.missed_mask[i] = 1'b1;
    end
    for (int i = 0; i < ptd_pkg::ACTIVE_TASKS; i++) begin
      elapsed = now - last_start_q[i];
      if (!outcome.dispatched && elapsed >= period_q[i]) begin
        outcome.dispatched = 1'b1;
        outcome.task_index = ptd_pkg::TASK_W'(i);
      end
    end
    if (outcome.dispatched) begin
      last_start_q[outcome.task_index] = now;
      deadline_q[outcome.task_index]   = now + period_q[outcome.task_index];
    end
    return outcome;
  endfunction

  function automatic logic [ptd_pkg::TIME_W-1:0] pick_period(input bit small_mode);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (small_mode) return (r == 0) ? '0 : ptd_pkg::TIME_W'($urandom_range(1, 24));
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return ptd_pkg::TIME_W'($urandom);
      3:       return ptd_pkg::TIME_W'(100);
      4:       return ptd_pkg::TIME_W'(500);
      5:       return ptd_pkg::TIME_W'(1000);
      default: return ptd_pkg::TIME_W'($urandom_range(1, 400));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      got_outcome.dispatched  = result_ch.dispatched;
      got_outcome.task_index  = result_ch.task_index;
      got_outcome.missed_mask = result_ch.missed_mask;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none actual %p", $time,
                 got_outcome);
        error_count++;
      end else begin
        want_outcome = pending_outcomes.pop_front();
        if (got_outcome.dispatched !== want_outcome.dispatched) begin
          $display("%0t: dispatched expected %0d actual %0d", $time,
                   want_outcome.dispatched, got_outcome.dispatched);
          error_count++;
        end
        if (got_outcome.task_index !== want_outcome.task_index) begin
          $display("%0t: task_index expected %0d actual %0d", $time,
                   want_outcome.task_index, got_outcome.task_index);
          error_count++;
        end
        if (got_outcome.missed_mask !== want_outcome.missed_mask) begin
          $display("%0t: missed_mask expected %b actual %b", $time,
                   want_outcome.missed_mask, got_outcome.missed_mask);
          error_count++;
        end
      end
    end
  end

  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_tick(input logic [ptd_pkg::TIME_W-1:0] now);
    tick_ch.valid  <= 1'b1;
    tick_ch.now_ms <= now;
    do @(posedge clk); while (!tick_ch.ready);
    pending_outcomes.push_back(schedule_tick(now));
  endtask

  task automatic offer_tick(input logic [ptd_pkg::TIME_W-1:0] now);
    send_tick(now);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_period(input logic [ptd_pkg::CFG_IDX_W-1:0] idx,
                              input logic [ptd_pkg::TIME_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < ptd_pkg::MAX_TASKS) period_q[idx[ptd_pkg::TASK_W-1:0]] = value;
  endtask

  task automatic load_periods(input logic [ptd_pkg::TIME_W-1:0] p0,
                              input logic [ptd_pkg::TIME_W-1:0] p1,
                              input logic [ptd_pkg::TIME_W-1:0] p2,
                              input logic [ptd_pkg::TIME_W-1:0] p3,
                              input bit stray);
    wait_drained();
    write_period(ptd_pkg::REG_PERIOD_TASK0, p0);
    write_period(REG_PERIOD_TASK1, p1);
    write_period(REG_PERIOD_TASK2, p2);
    write_period(REG_PERIOD_TASK3, p3);
    if (stray) write_period(ptd_pkg::CFG_IDX_W'($urandom_range(ptd_pkg::MAX_TASKS, 255)),
                            ptd_pkg::TIME_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic walk_ticks(input int count, input int step_max);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(0, 19);
      if (r == 0) tick_time = ptd_pkg::TIME_W'($urandom);
      else if (r == 1) tick_time = tick_time - ptd_pkg::TIME_W'($urandom_range(1, 50));
      else tick_time = tick_time + ptd_pkg::TIME_W'($urandom_range(0, step_max));
      offer_tick(tick_time);
    end
  endtask

  task automatic run_phase(input int count, input bit small_mode);
    load_periods(pick_period(small_mode), pick_period(small_mode), pick_period(small_mode),
                 pick_period(small_mode), bit'($urandom_range(0, 1)));
    tick_time = ($urandom_range(0, 2) == 0) ?
                ('1 - ptd_pkg::TIME_W'($urandom_range(0, 800))) :
                ptd_pkg::TIME_W'($urandom);
    walk_ticks(count, small_mode ? 10 : 400);
  endtask

  task automatic test_reset_periods();
    offer_tick(ptd_pkg::TIME_W'(0));
    offer_tick(ptd_pkg::TIME_W'(99));
    offer_tick(ptd_pkg::TIME_W'(100));
    offer_tick(ptd_pkg::TIME_W'(150));
    offer_tick(ptd_pkg::TIME_W'(250));
    offer_tick(ptd_pkg::TIME_W'(600));
    offer_tick(ptd_pkg::TIME_W'(1650));
    offer_tick('1);
  endtask

  task automatic test_stray_index();
    wait_drained();
    write_period(REG_STRAY_LOW, '1);
    write_period(REG_STRAY_HIGH, '0);
    cfg_ch.valid <= 1'b0;
    offer_tick(ptd_pkg::TIME_W'(1700));
    offer_tick(ptd_pkg::TIME_W'(1800));
  endtask

  task automatic test_zero_period();
    load_periods('0, '0, '0, '0, 1'b0);
    offer_tick(ptd_pkg::TIME_W'(1800));
    offer_tick(ptd_pkg::TIME_W'(1800));
    offer_tick(ptd_pkg::TIME_W'(1801));
    load_periods('1, '0, ptd_pkg::TIME_W'(5), ptd_pkg::TIME_W'(5), 1'b0);
    offer_tick(ptd_pkg::TIME_W'(1802));
    offer_tick(ptd_pkg::TIME_W'(1802));
  endtask

  task automatic test_deadline_wrap();
    load_periods(ptd_pkg::TIME_W'(16), '1, '1, '1, 1'b0);
    offer_tick(32'hFFFF_FFF0);
    offer_tick(32'hFFFF_FFF5);
    offer_tick(32'h0000_0000);
    offer_tick(32'h0000_0020);
    load_periods('1, '1, '1, '1, 1'b0);
    offer_tick(last_start_q[0] - ptd_pkg::TIME_W'(1));
  endtask

  task automatic test_random_small();
    repeat (3) run_phase(250, 1'b1);
  endtask

  task automatic test_random_mixed();
    repeat (2) run_phase(200, 1'b0);
  endtask

  task automatic test_output_stall();
    load_periods(ptd_pkg::TIME_W'(7), ptd_pkg::TIME_W'(3), ptd_pkg::TIME_W'(11),
                 ptd_pkg::TIME_W'(2), 1'b0);
    tick_time = ptd_pkg::TIME_W'($urandom);
    rx_hold_req = 1'b1;
    walk_ticks(60, 6);
    wait_drained();
    walk_ticks(30, 6);
  endtask

  task automatic test_quiet_tail();
    quiet_tail = 1'b1;
    run_phase(150, 1'b1);
  endtask

  initial begin
    rst            <= 1'b1;
    tick_ch.valid  <= 1'b0;
    tick_ch.now_ms <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    for (int i = 0; i < ptd_pkg::MAX_TASKS; i++) begin
      period_q[i]     = ptd_pkg::reset_period(ptd_pkg::TASK_W'(i));
      last_start_q[i] = '0;
      deadline_q[i]   = '0;
    end
    tick_time = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_periods();
    test_stray_index();
    test_zero_period();
    test_deadline_wrap();
    test_random_small();
    test_random_mixed();
    test_output_stall();
    test_quiet_tail();
    wait_drained();

    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
